>>> sv/json_body_value_extractor_assert.svh
// Assertion macros shared by the checker.
`ifndef JSON_BODY_VALUE_EXTRACTOR_ASSERT_SVH
`define JSON_BODY_VALUE_EXTRACTOR_ASSERT_SVH

`define JBVE_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define JBVE_ASSERT(label, prop) `JBVE_ASSERT_IMPL(label, i_clk, i_rst_n, prop)

`endif

>>> sv/jbve_pkg.sv
package jbve_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int OFFSET_BITS = 20;
    localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);
    localparam int SP_BITS = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef enum logic [3:0] {
        PM_VALUE, PM_ARR_FIRST, PM_OBJ_FIRST, PM_KEY, PM_KEY_STR,
        PM_COLON, PM_STR, PM_NUM, PM_LIT, PM_AFTER
    } t_mode;

    typedef enum logic [2:0] {
        EV_STRING  = 3'd0,
        EV_NUMBER  = 3'd1,
        EV_LITERAL = 3'd2,
        EV_KEY     = 3'd3,
        EV_VERDICT = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        LIT_TRUE  = 2'd0,
        LIT_FALSE = 2'd1,
        LIT_NULL  = 2'd2
    } t_lit;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [19:0] key_offset;
        logic [19:0] key_length;
        logic [19:0] value_offset;
        logic [19:0] value_length;
        logic        body_invalid;
        logic        last_result;
    } t_event;

    // One queue entry: up to two events caused by one byte.
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_event e0;
        t_event e1;
    } t_pair;

    function automatic logic is_ws(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a;
    endfunction

    function automatic logic is_num_char(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || b == 8'h2e || b == 8'h2b ||
               b == 8'h2d || b == 8'h65 || b == 8'h45;
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5a) ? (b | 8'h20) : b;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] w);
        return (w == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (w)
            LIT_TRUE: begin
                case (p)
                    3'd1: c = 8'h72;
                    3'd2: c = 8'h75;
                    3'd3: c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                case (p)
                    3'd1: c = 8'h61;
                    3'd2: c = 8'h6c;
                    3'd3: c = 8'h73;
                    3'd4: c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            LIT_NULL: begin
                case (p)
                    3'd1: c = 8'h75;
                    3'd2: c = 8'h6c;
                    3'd3: c = 8'h6c;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> sv/jbve_if.sv
interface jbve_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source(output valid, data_byte, last_byte, input ready);
    modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface jbve_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [19:0] key_offset;
    logic [19:0] key_length;
    logic [19:0] value_offset;
    logic [19:0] value_length;
    logic        body_invalid;
    logic        last_result;
    modport source(output valid, event_kind, key_offset, key_length, value_offset,
        value_length, body_invalid, last_result, input ready);
    modport sink(input valid, event_kind, key_offset, key_length, value_offset,
        value_length, body_invalid, last_result, output ready);
endinterface

>>> sv/jbve_front.sv
module jbve_front
    import jbve_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_space,
    output logic       o_push,
    output t_pair      o_pair
);

    t_mode                  r_mode, n_mode;
    logic [MAX_DEPTH-1:0]   r_stack, n_stack;
    logic [DEPTH_BITS-1:0]  r_depth, n_depth;
    logic [OFFSET_BITS-1:0] r_pos, n_pos, r_kst, n_kst, r_ksz, n_ksz;
    logic [OFFSET_BITS-1:0] r_vst, n_vst, r_vsz, n_vsz;
    logic [2:0]             r_lp, n_lp;
    logic [1:0]             r_lw, n_lw;
    logic                   r_esc, n_esc, r_err, n_err;

    logic                   fire;
    logic [7:0]             b;
    logic                   top;
    logic [SP_BITS-1:0]     sp_top, sp_push;

    assign o_ready = i_space;
    assign fire = i_valid && i_space;
    assign b = i_data_byte;
    assign sp_top = SP_BITS'(r_depth - DEPTH_BITS'(1));
    assign sp_push = SP_BITS'(r_depth);
    assign top = r_stack[sp_top];

    function automatic t_event mk(input t_kind k, input logic [OFFSET_BITS-1:0] ks,
        input logic [OFFSET_BITS-1:0] kz, input logic [OFFSET_BITS-1:0] vo,
        input logic [OFFSET_BITS-1:0] vl, input logic inv, input logic lst);
        t_event e;
        e.event_kind   = k;
        e.key_offset   = 20'(ks);
        e.key_length   = 20'(kz);
        e.value_offset = 20'(vo);
        e.value_length = 20'(vl);
        e.body_invalid = inv;
        e.last_result  = lst;
        return e;
    endfunction

    always_comb begin
        logic ev_v;
        t_event ev;
        logic go_after;
        logic ok;
        ev_v = 1'b0;
        ev = '0;
        go_after = 1'b0;
        ok = 1'b0;
        n_mode = r_mode; n_stack = r_stack; n_depth = r_depth; n_pos = r_pos;
        n_kst = r_kst; n_ksz = r_ksz; n_vst = r_vst; n_vsz = r_vsz;
        n_lp = r_lp; n_lw = r_lw; n_esc = r_esc; n_err = r_err;
        o_pair = '0;

        if (!r_err) begin
            case (r_mode)
                PM_NUM: begin
                    if (is_num_char(b)) begin
                        n_vsz = r_vsz + OFFSET_BITS'(1);
                    end else begin
                        ev_v = 1'b1;
                        ev = mk(EV_NUMBER, r_kst, r_ksz, r_vst, r_vsz, 1'b0, 1'b0);
                        n_mode = PM_AFTER;
                        go_after = 1'b1;
                    end
                end
                PM_VALUE, PM_ARR_FIRST: begin
                    if (r_mode == PM_ARR_FIRST && b == 8'h5d) begin
                        n_depth = r_depth - DEPTH_BITS'(1);
                        n_mode = PM_AFTER;
                    end else if (is_ws(b)) begin
                    end else if (b == 8'h22) begin
                        n_mode = PM_STR;
                        n_vst = r_pos + OFFSET_BITS'(1);
                        n_vsz = '0;
                        n_esc = 1'b0;
                    end else if ((b >= 8'h30 && b <= 8'h39) || b == 8'h2d) begin
                        n_mode = PM_NUM;
                        n_vst = r_pos;
                        n_vsz = OFFSET_BITS'(1);
                    end else if (lower(b) == 8'h74 || lower(b) == 8'h66 ||
                                 lower(b) == 8'h6e) begin
                        n_mode = PM_LIT;
                        n_lw = (lower(b) == 8'h74) ? LIT_TRUE :
                               (lower(b) == 8'h66) ? LIT_FALSE : LIT_NULL;
                        n_lp = 3'd1;
                        n_vst = r_pos;
                    end else if (b == 8'h5b || b == 8'h7b) begin
                        if (b == 8'h7b) begin
                            ev_v = 1'b1;
                            ev = mk(EV_KEY, r_kst, r_ksz, r_pos, '0, 1'b0, 1'b0);
                        end
                        if (32'(r_depth) + 1 > MAX_DEPTH) begin
                            n_err = 1'b1;
                        end else begin
                            n_stack[sp_push] = (b == 8'h7b);
                            n_depth = r_depth + DEPTH_BITS'(1);
                            n_mode = (b == 8'h7b) ? PM_OBJ_FIRST : PM_ARR_FIRST;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PM_OBJ_FIRST, PM_KEY: begin
                    if (is_ws(b)) begin
                    end else if (b == 8'h7d && r_mode == PM_OBJ_FIRST) begin
                        n_depth = r_depth - DEPTH_BITS'(1);
                        n_mode = PM_AFTER;
                    end else if (b == 8'h22) begin
                        n_mode = PM_KEY_STR;
                        n_kst = r_pos + OFFSET_BITS'(1);
                        n_ksz = '0;
                        n_esc = 1'b0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PM_KEY_STR, PM_STR: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (b == 8'h22) begin
                        if (r_mode == PM_STR) begin
                            ev_v = 1'b1;
                            ev = mk(EV_STRING, r_kst, r_ksz, r_vst, r_vsz, 1'b0, 1'b0);
                            n_mode = PM_AFTER;
                        end else begin
                            n_mode = PM_COLON;
                        end
                    end else if (b == 8'h00 &&
                                 ((r_mode == PM_STR) ? r_vsz : r_ksz) == '0) begin
                        n_err = 1'b1;
                    end else if (b == 8'h5c) begin
                        n_esc = 1'b1;
                    end
                    if (!(r_esc == 1'b0 && b == 8'h22) &&
                        !(r_esc == 1'b0 && b == 8'h00 &&
                          ((r_mode == PM_STR) ? r_vsz : r_ksz) == '0)) begin
                        if (r_mode == PM_STR) n_vsz = r_vsz + OFFSET_BITS'(1);
                        else n_ksz = r_ksz + OFFSET_BITS'(1);
                    end
                end
                PM_COLON: begin
                    if (b == 8'h3a) n_mode = PM_VALUE;
                    else if (!is_ws(b)) n_err = 1'b1;
                end
                PM_LIT: begin
                    if (r_lw == 2'd3 || r_lp >= lit_len(r_lw) ||
                        lower(b) != lit_char(r_lw, r_lp)) begin
                        n_err = 1'b1;
                    end else begin
                        n_lp = r_lp + 3'd1;
                        if (n_lp == lit_len(r_lw)) begin
                            ev_v = 1'b1;
                            ev = mk(EV_LITERAL, r_kst, r_ksz, r_vst,
                                OFFSET_BITS'(lit_len(r_lw)), 1'b0, 1'b0);
                            n_mode = PM_AFTER;
                        end
                    end
                end
                default: go_after = 1'b1;
            endcase

            if (go_after && !is_ws(b)) begin
                if (r_depth == '0 || 32'(r_depth) > MAX_DEPTH) begin
                    n_err = 1'b1;
                end else if (b == 8'h2c) begin
                    n_mode = top ? PM_KEY : PM_VALUE;
                end else if ((b == 8'h5d && !top) || (b == 8'h7d && top)) begin
                    n_depth = r_depth - DEPTH_BITS'(1);
                end else begin
                    n_err = 1'b1;
                end
            end
        end

        o_pair.v0 = ev_v;
        o_pair.e0 = ev;
        if (i_last_byte) begin
            if (!n_err && n_mode == PM_NUM) begin
                if (!ev_v) begin
                    o_pair.v0 = 1'b1;
                    o_pair.e0 = mk(EV_NUMBER, n_kst, n_ksz, n_vst, n_vsz, 1'b0, 1'b0);
                end else begin
                    o_pair.v1 = 1'b1;
                    o_pair.e1 = mk(EV_NUMBER, n_kst, n_ksz, n_vst, n_vsz, 1'b0, 1'b0);
                end
                n_mode = PM_AFTER;
            end
            ok = !n_err && n_mode == PM_AFTER && n_depth == '0;
            if (!o_pair.v0) begin
                o_pair.v0 = 1'b1;
                o_pair.e0 = mk(EV_VERDICT, n_kst, n_ksz, '0, '0, !ok, 1'b1);
            end else begin
                o_pair.v1 = 1'b1;
                o_pair.e1 = mk(EV_VERDICT, n_kst, n_ksz, '0, '0, !ok, 1'b1);
            end
            n_mode = PM_VALUE; n_depth = '0; n_pos = '0; n_kst = '0; n_ksz = '0;
            n_vst = '0; n_vsz = '0; n_lp = '0; n_lw = '0; n_esc = 1'b0; n_err = 1'b0;
        end else begin
            n_pos = r_pos + OFFSET_BITS'(1);
        end
        o_push = fire && o_pair.v0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= PM_VALUE; r_depth <= '0; r_pos <= '0; r_kst <= '0; r_ksz <= '0;
            r_vst <= '0; r_vsz <= '0; r_lp <= '0; r_lw <= '0; r_esc <= 1'b0;
            r_err <= 1'b0;
        end else if (fire) begin
            r_mode <= n_mode; r_depth <= n_depth; r_pos <= n_pos; r_kst <= n_kst;
            r_ksz <= n_ksz; r_vst <= n_vst; r_vsz <= n_vsz; r_lp <= n_lp;
            r_lw <= n_lw; r_esc <= n_esc; r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) r_stack <= n_stack;
    end

endmodule

>>> sv/jbve_queue.sv
module jbve_queue
    import jbve_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_pair,
    output logic  o_space,
    output logic  o_valid,
    output t_pair o_pair,
    input  logic  i_pop
);

    t_pair                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QPTR_BITS:0]   r_cnt;

    assign o_space = r_cnt < (QPTR_BITS+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_pair = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_BITS'(1);
            if (i_pop) r_rd <= r_rd + QPTR_BITS'(1);
            r_cnt <= r_cnt + (QPTR_BITS+1)'(i_push) - (QPTR_BITS+1)'(i_pop);
        end
    end

endmodule

>>> sv/jbve_back.sv
module jbve_back
    import jbve_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_pair  i_pair,
    output logic   o_pop,
    output logic   o_valid,
    output t_event o_event,
    input  logic   i_ready
);

    logic   r_valid, r_second;
    t_event r_event;
    logic   load, take_second;

    assign o_valid = r_valid;
    assign o_event = r_event;
    assign load = !r_valid || i_ready;
    assign take_second = i_valid && i_pair.v1 && !r_second;
    assign o_pop = load && i_valid && !take_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) r_second <= take_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) r_event <= r_second ? i_pair.e1 : i_pair.e0;
    end

endmodule

>>> sv/json_body_value_extractor.sv
// Channel   Role     Payload
// i_in      sink     data_byte, last_byte
// o_out     source   event_kind, key/value offsets and lengths, verdict
// One byte per cycle is accepted while the queue has space; the parser state updates as each byte is accepted.
// A byte may cause two events; the output stage sends them one after the other.
// A four-entry queue between parser and output lets either side stall.
// Synchronous active-low reset returns the parser to the start of a body.
module json_body_value_extractor
    import jbve_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    jbve_in_if.sink      i_in,
    jbve_out_if.source   o_out
);

    logic   push, space, q_valid, pop;
    t_pair  f_pair, q_pair;
    t_event ev;

    jbve_front u_front (
        .i_clk, .i_rst_n, .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_data_byte(i_in.data_byte), .i_last_byte(i_in.last_byte),
        .i_space(space), .o_push(push), .o_pair(f_pair)
    );

    jbve_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_pair(f_pair), .o_space(space),
        .o_valid(q_valid), .o_pair(q_pair), .i_pop(pop)
    );

    jbve_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_pair(q_pair), .o_pop(pop),
        .o_valid(o_out.valid), .o_event(ev), .i_ready(o_out.ready)
    );

    assign o_out.event_kind   = ev.event_kind;
    assign o_out.key_offset   = ev.key_offset;
    assign o_out.key_length   = ev.key_length;
    assign o_out.value_offset = ev.value_offset;
    assign o_out.value_length = ev.value_length;
    assign o_out.body_invalid = ev.body_invalid;
    assign o_out.last_result  = ev.last_result;

endmodule

>>> sv/jbve_checker.sv
`include "json_body_value_extractor_assert.svh"

module jbve_checker
    import jbve_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  event_kind,
    input logic        last_result,
    input logic        body_invalid,
    input logic [19:0] value_length
);

    `JBVE_ASSERT(a_last_kind, out_valid |-> (last_result == (event_kind == EV_VERDICT)))
    `JBVE_ASSERT(a_kind_range, out_valid |-> event_kind <= EV_VERDICT)
    `JBVE_ASSERT(a_inv_verdict, (out_valid && body_invalid) |-> event_kind == EV_VERDICT)
    `JBVE_ASSERT(a_hold, (out_valid && !out_ready) |=> out_valid)
    `JBVE_ASSERT(a_keylen, (out_valid && event_kind == EV_KEY) |-> value_length == 20'd0)

endmodule

bind json_body_value_extractor jbve_checker u_checker (
    .i_clk, .i_rst_n,
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .event_kind(o_out.event_kind), .last_result(o_out.last_result),
    .body_invalid(o_out.body_invalid), .value_length(o_out.value_length)
);
